[rtl/frt_pkg.sv]
// frt_pkg: shared widths, result codes and control structs for the fragment
// reassembly tracker. No dependencies; used by every module under rtl/.
package frt_pkg;

    localparam int IN_W    = 48;
    localparam int PKT_W   = 16;
    localparam int CNT_W   = 8;
    localparam int BYTES_W = 16;
    localparam int EPOCH_W = 10;

    localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

    typedef enum logic [1:0] {
        ST_PENDING  = 2'd0,
        ST_DUP      = 2'd1,
        ST_COMPLETE = 2'd2,
        ST_ERROR    = 2'd3
    } status_t;

    typedef struct packed {
        status_t status;
        logic    used;
        logic    evicted;
        logic    cleared;
    } res_flags_t;

    typedef struct packed {
        logic wr_en;
        logic clr_start;
    } mem_req_t;

endpackage

[rtl/fragment_reassembly_tracker.sv]
// fragment_reassembly_tracker: top level with stream ports, header register,
// result register and tag forwarding. Depends on frt_pkg, frt_seen_mem, frt_slot_core.
//
// Tracks fragment headers over NUM_SLOTS reassembly slots with least recently
// used replacement and answers one result per header. One header is taken per
// clock unless a clearing pass, a pending epoch wrap or a held result stalls it:
// it is registered together with the read of the fragment tag memory, decided in
// one pass over the slot table, and the result is registered on the output side,
// so a header can be taken while an earlier result is still held.
// Received fragments are kept as epoch tags in one FRAG_BITS-deep memory per
// slot; after reset a clearing pass over all FRAG_BITS rows runs during which no
// header is taken (configuration writes are always taken). The same pass, for
// one slot, follows the opening at which that slot's epoch wraps: its 1024th
// opening and every 1023rd one after that, counting openings that keep the slot.
module fragment_reassembly_tracker #(
    parameter int NUM_SLOTS = 4,
    parameter int FRAG_BITS = 256,
    localparam int SLOT_W   = $clog2(NUM_SLOTS),
    localparam int OUT_BITS = 3 + SLOT_W + frt_pkg::BYTES_W,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // packet_number, fragment_total, fragment_index, fragment_bytes
    input  logic [frt_pkg::IN_W-1:0]      s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // slot_used, slot_index, slot_evicted, slot_cleared, total_bytes, zero fill
    output logic [OUT_W-1:0]              m_tdata,
    // status
    output logic [1:0]                    m_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [frt_pkg::BYTES_W-1:0]   cfg_data
);
    import frt_pkg::*;

    localparam int ROW_W = $clog2(FRAG_BITS);

    logic                 stg_valid_reg;
    logic [PKT_W-1:0]     stg_pkt_reg;
    logic [CNT_W-1:0]     stg_total_reg;
    logic [CNT_W-1:0]     stg_idx_reg;
    logic [BYTES_W-1:0]   stg_len_reg;
    logic [BYTES_W-1:0]   max_bytes_reg;

    logic                 out_valid_reg;
    res_flags_t           out_flags_reg;
    logic [SLOT_W-1:0]    out_slot_reg;
    logic [BYTES_W-1:0]   out_bytes_reg;

    logic                 fwd_valid_reg;
    logic [SLOT_W-1:0]    fwd_slot_reg;
    logic [ROW_W-1:0]     fwd_row_reg;
    logic [EPOCH_W-1:0]   fwd_tag_reg;

    logic                 accept, stage_fire, mem_busy, wrap_pending;
    logic [ROW_W-1:0]     stg_row;
    logic [NUM_SLOTS-1:0][EPOCH_W-1:0] rd_tags, tags;
    res_flags_t           flags;
    logic [SLOT_W-1:0]    slot_index;
    logic [BYTES_W-1:0]   total_bytes;
    mem_req_t             req;
    logic [SLOT_W-1:0]    wr_slot;
    logic [EPOCH_W-1:0]   wr_tag;

    assign stage_fire = stg_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready   = (!stg_valid_reg || stage_fire) && !mem_busy && !wrap_pending;
    assign accept     = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;
    assign stg_row    = stg_idx_reg[ROW_W-1:0];

    // the previous item's tag write lands in the same edge as this item's read
    always_comb
    begin
        tags = rd_tags;
        if (fwd_valid_reg && fwd_row_reg == stg_row)
        begin
            tags[fwd_slot_reg] = fwd_tag_reg;
        end
    end

    frt_seen_mem #(
        .NUM_SLOTS (NUM_SLOTS),
        .FRAG_BITS (FRAG_BITS),
        .SLOT_W    (SLOT_W),
        .ROW_W     (ROW_W)
    ) u_seen_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_row  (s_tdata[24 +: ROW_W]),
        .rd_tags (rd_tags),
        .req     (req),
        .wr_slot (wr_slot),
        .wr_row  (stg_row),
        .wr_tag  (wr_tag),
        .busy    (mem_busy)
    );

    frt_slot_core #(
        .NUM_SLOTS (NUM_SLOTS),
        .FRAG_BITS (FRAG_BITS),
        .SLOT_W    (SLOT_W)
    ) u_slot_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .valid        (stg_valid_reg),
        .fire         (stage_fire),
        .pkt          (stg_pkt_reg),
        .total        (stg_total_reg),
        .idx          (stg_idx_reg),
        .len          (stg_len_reg),
        .max_bytes    (max_bytes_reg),
        .tags         (tags),
        .res          (flags),
        .slot_index   (slot_index),
        .total_bytes  (total_bytes),
        .req          (req),
        .wr_slot      (wr_slot),
        .wr_tag       (wr_tag),
        .wrap_pending (wrap_pending)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
            max_bytes_reg <= '1;
        end
        else
        begin
            if (accept)
            begin
                stg_valid_reg <= 1'b1;
                fwd_valid_reg <= stage_fire && req.wr_en;
            end
            else if (stage_fire)
            begin
                stg_valid_reg <= 1'b0;
            end
            if (stage_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                max_bytes_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_pkt_reg   <= s_tdata[15:0];
            stg_total_reg <= s_tdata[23:16];
            stg_idx_reg   <= s_tdata[31:24];
            stg_len_reg   <= s_tdata[47:32];
            fwd_slot_reg  <= wr_slot;
            fwd_row_reg   <= stg_row;
            fwd_tag_reg   <= wr_tag;
        end
        if (stage_fire)
        begin
            out_flags_reg <= flags;
            out_slot_reg  <= slot_index;
            out_bytes_reg <= total_bytes;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_flags_reg.status;
    assign m_tdata  = OUT_W'({out_bytes_reg, out_flags_reg.cleared, out_flags_reg.evicted,
                              out_slot_reg, out_flags_reg.used});

endmodule

[rtl/frt_seen_mem.sv]
// frt_seen_mem: one received-fragment tag memory per slot, with a clearing
// sweep run after reset and on epoch wrap. Depends on frt_pkg.
module frt_seen_mem #(
    parameter int NUM_SLOTS = 4,
    parameter int FRAG_BITS = 256,
    parameter int SLOT_W    = 2,
    parameter int ROW_W     = 8
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      rd_en,
    input  logic [ROW_W-1:0]                          rd_row,
    output logic [NUM_SLOTS-1:0][frt_pkg::EPOCH_W-1:0] rd_tags,
    input  frt_pkg::mem_req_t                         req,
    input  logic [SLOT_W-1:0]                         wr_slot,
    input  logic [ROW_W-1:0]                          wr_row,
    input  logic [frt_pkg::EPOCH_W-1:0]               wr_tag,
    output logic                                      busy
);
    import frt_pkg::*;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(FRAG_BITS - 1);

    logic                 busy_reg, busy_next;
    logic [ROW_W-1:0]     ptr_reg, ptr_next;
    logic [NUM_SLOTS-1:0] mask_reg, mask_next;
    logic                 keep_valid_reg, keep_valid_next;
    logic [ROW_W-1:0]     keep_row_reg, keep_row_next;
    logic                 sweep_we;

    assign busy = busy_reg;
    // the row just written by the wrapping item must survive the sweep
    assign sweep_we = busy_reg && !(keep_valid_reg && ptr_reg == keep_row_reg);

    always_comb
    begin
        busy_next       = busy_reg;
        ptr_next        = ptr_reg;
        mask_next       = mask_reg;
        keep_valid_next = keep_valid_reg;
        keep_row_next   = keep_row_reg;
        if (req.clr_start)
        begin
            busy_next       = 1'b1;
            ptr_next        = '0;
            mask_next       = '0;
            mask_next[wr_slot] = 1'b1;
            keep_valid_next = 1'b1;
            keep_row_next   = wr_row;
        end
        else if (busy_reg)
        begin
            ptr_next = ptr_reg + 1'b1;
            if (ptr_reg == LAST_ROW)
            begin
                busy_next = 1'b0;
                ptr_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b1;
            ptr_reg        <= '0;
            mask_reg       <= '1;
            keep_valid_reg <= 1'b0;
            keep_row_reg   <= '0;
        end
        else
        begin
            busy_reg       <= busy_next;
            ptr_reg        <= ptr_next;
            mask_reg       <= mask_next;
            keep_valid_reg <= keep_valid_next;
            keep_row_reg   <= keep_row_next;
        end
    end

    for (genvar g = 0; g < NUM_SLOTS; g++)
    begin : g_slot_mem
        logic [EPOCH_W-1:0] mem [FRAG_BITS];
        logic [EPOCH_W-1:0] rd_q;

        always_ff @(posedge clk)
        begin
            if (sweep_we && mask_reg[g])
            begin
                mem[ptr_reg] <= '0;
            end
            else if (req.wr_en && wr_slot == SLOT_W'(g))
            begin
                mem[wr_row] <= wr_tag;
            end
            if (rd_en)
            begin
                rd_q <= mem[rd_row];
            end
        end

        assign rd_tags[g] = rd_q;
    end

endmodule

[rtl/frt_slot_core.sv]
// frt_slot_core: slot table (match, open, evict, release, recency ranks,
// epochs) and the per-item decision logic. Depends on frt_pkg.
module frt_slot_core #(
    parameter int NUM_SLOTS = 4,
    parameter int FRAG_BITS = 256,
    parameter int SLOT_W    = 2
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       valid,
    input  logic                                       fire,
    input  logic [frt_pkg::PKT_W-1:0]                  pkt,
    input  logic [frt_pkg::CNT_W-1:0]                  total,
    input  logic [frt_pkg::CNT_W-1:0]                  idx,
    input  logic [frt_pkg::BYTES_W-1:0]                len,
    input  logic [frt_pkg::BYTES_W-1:0]                max_bytes,
    input  logic [NUM_SLOTS-1:0][frt_pkg::EPOCH_W-1:0] tags,
    output frt_pkg::res_flags_t                        res,
    output logic [SLOT_W-1:0]                          slot_index,
    output logic [frt_pkg::BYTES_W-1:0]                total_bytes,
    output frt_pkg::mem_req_t                          req,
    output logic [SLOT_W-1:0]                          wr_slot,
    output logic [frt_pkg::EPOCH_W-1:0]                wr_tag,
    output logic                                       wrap_pending
);
    import frt_pkg::*;

    localparam logic [CNT_W:0]    FRAG_LIM = (CNT_W + 1)'(FRAG_BITS);
    localparam logic [SLOT_W-1:0] OLDEST   = SLOT_W'(NUM_SLOTS - 1);

    logic [NUM_SLOTS-1:0]                valid_reg, valid_next;
    logic [NUM_SLOTS-1:0][PKT_W-1:0]     packet_reg, packet_next;
    logic [NUM_SLOTS-1:0][CNT_W-1:0]     expected_reg, expected_next;
    logic [NUM_SLOTS-1:0][CNT_W-1:0]     received_reg, received_next;
    logic [NUM_SLOTS-1:0][BYTES_W-1:0]   bytes_reg, bytes_next;
    logic [NUM_SLOTS-1:0][SLOT_W-1:0]    rank_reg, rank_next;
    logic [NUM_SLOTS-1:0][EPOCH_W-1:0]   epoch_reg, epoch_next;

    logic               hdr_ok, single;
    logic               hit, free_any;
    logic [SLOT_W-1:0]  hit_idx, free_idx, victim_idx, s;
    logic               mismatch, seen, overflow, complete;
    logic [BYTES_W:0]   sum;
    logic [CNT_W-1:0]   rcv_next;
    logic               pending, dup, keep, slot_step, wrap;
    logic [EPOCH_W-1:0] epoch_new;

    always_comb
    begin
        hdr_ok = total != '0 && idx < total && {1'b0, total} <= FRAG_LIM;
        single = total == CNT_W'(1);

        hit = 1'b0;
        hit_idx = '0;
        free_any = 1'b0;
        free_idx = '0;
        victim_idx = '0;
        // downward scans so that the lowest matching slot wins
        for (int j = NUM_SLOTS - 1; j >= 0; j--)
        begin
            if (valid_reg[j] && packet_reg[j] == pkt)
            begin
                hit = 1'b1;
                hit_idx = SLOT_W'(j);
            end
            if (!valid_reg[j])
            begin
                free_any = 1'b1;
                free_idx = SLOT_W'(j);
            end
            if (rank_reg[j] == OLDEST)
            begin
                victim_idx = SLOT_W'(j);
            end
        end

        s = hit ? hit_idx : (free_any ? free_idx : victim_idx);
        mismatch = hit && expected_reg[s] != total;
        seen = hit && tags[s] == epoch_reg[s];
        sum = {1'b0, (hit ? bytes_reg[s] : BYTES_W'(0))} + {1'b0, len};
        overflow = sum > {1'b0, max_bytes};
        rcv_next = (hit ? received_reg[s] : CNT_W'(0)) + 1'b1;
        complete = rcv_next == total;

        slot_step = hdr_ok && !single;
        dup = slot_step && !mismatch && seen;
        pending = slot_step && !mismatch && !seen && !overflow && !complete;
        keep = dup || pending;
        epoch_new = (epoch_reg[s] == EPOCH_MAX) ? EPOCH_FIRST : epoch_reg[s] + 1'b1;
        wrap = pending && !hit && epoch_reg[s] == EPOCH_MAX;
    end

    always_comb
    begin
        res.status  = ST_ERROR;
        res.used    = 1'b0;
        res.evicted = 1'b0;
        res.cleared = 1'b0;
        slot_index  = '0;
        total_bytes = '0;
        if (hdr_ok && single)
        begin
            res.status  = ST_COMPLETE;
            total_bytes = len;
        end
        else if (slot_step)
        begin
            res.used   = 1'b1;
            slot_index = s;
            if (mismatch)
            begin
                res.cleared = 1'b1;
            end
            else
            begin
                res.evicted = !hit && !free_any;
                priority if (seen)
                begin
                    res.status = ST_DUP;
                end
                else if (overflow)
                begin
                    res.cleared = 1'b1;
                end
                else if (complete)
                begin
                    res.status  = ST_COMPLETE;
                    res.cleared = 1'b1;
                    total_bytes = sum[BYTES_W-1:0];
                end
                else
                begin
                    res.status = ST_PENDING;
                end
            end
        end
    end

    assign req.wr_en     = fire && pending;
    assign req.clr_start = fire && wrap;
    assign wr_slot       = s;
    assign wr_tag        = hit ? epoch_reg[s] : epoch_new;
    assign wrap_pending  = valid && wrap;

    always_comb
    begin
        valid_next    = valid_reg;
        packet_next   = packet_reg;
        expected_next = expected_reg;
        received_next = received_reg;
        bytes_next    = bytes_reg;
        rank_next     = rank_reg;
        epoch_next    = epoch_reg;
        if (fire && slot_step)
        begin
            for (int j = 0; j < NUM_SLOTS; j++)
            begin
                if (SLOT_W'(j) != s && valid_reg[j])
                begin
                    if (hit && keep && rank_reg[j] < rank_reg[s])
                    begin
                        rank_next[j] = rank_reg[j] + 1'b1;
                    end
                    else if (hit && !keep && rank_reg[j] > rank_reg[s])
                    begin
                        rank_next[j] = rank_reg[j] - 1'b1;
                    end
                    else if (!hit && keep)
                    begin
                        rank_next[j] = rank_reg[j] + 1'b1;
                    end
                end
            end
            valid_next[s] = keep;
            rank_next[s]  = '0;
            if (pending)
            begin
                received_next[s] = rcv_next;
                bytes_next[s]    = sum[BYTES_W-1:0];
                if (!hit)
                begin
                    packet_next[s]   = pkt;
                    expected_next[s] = total;
                    epoch_next[s]    = epoch_new;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            packet_reg   <= '0;
            expected_reg <= '0;
            received_reg <= '0;
            bytes_reg    <= '0;
            rank_reg     <= '0;
            epoch_reg    <= '0;
        end
        else
        begin
            valid_reg    <= valid_next;
            packet_reg   <= packet_next;
            expected_reg <= expected_next;
            received_reg <= received_next;
            bytes_reg    <= bytes_next;
            rank_reg     <= rank_next;
            epoch_reg    <= epoch_next;
        end
    end

endmodule

[tb/fragment_tracker_checker.sv]
// fragment_tracker_checker: watches the header, result and limit channels of the
// fragment reassembly tracker, predicts every result and compares it field by field.
// Depends on frt_pkg for the status codes; instantiated by fragment_reassembly_tracker_tb.
module fragment_tracker_checker #(
    parameter int NUM_SLOTS = 4,
    parameter int FRAG_BITS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // packet_number, fragment_total, fragment_index, fragment_bytes
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // slot_used, slot_index, slot_evicted, slot_cleared, total_bytes, zero fill
    input  logic [23:0] m_tdata,
    // status
    input  logic [1:0]  m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import frt_pkg::*;

    typedef struct packed {
        status_t     status;
        logic        used;
        logic [1:0]  slot;
        logic        evicted;
        logic        cleared;
        logic [15:0] length;
    } tracker_result_t;

    int unsigned     byte_limit;
    bit              slot_live [NUM_SLOTS];
    logic [15:0]     slot_pkt  [NUM_SLOTS];
    int unsigned     slot_want [NUM_SLOTS];
    int unsigned     slot_got  [NUM_SLOTS];
    int unsigned     slot_sum  [NUM_SLOTS];
    int unsigned     slot_age  [NUM_SLOTS];
    bit              frag_map  [NUM_SLOTS][FRAG_BITS];
    tracker_result_t expected_q [$];

    // older slots move up one rank to close the gap
    function automatic void free_slot(input int s);
        for (int j = 0; j < NUM_SLOTS; j++)
            if (j != s && slot_live[j] && slot_age[j] > slot_age[s])
                slot_age[j]--;
        slot_live[s] = 1'b0;
        slot_pkt[s]  = '0;
        slot_want[s] = 0;
        slot_got[s]  = 0;
        slot_sum[s]  = 0;
        slot_age[s]  = 0;
        for (int b = 0; b < FRAG_BITS; b++)
            frag_map[s][b] = 1'b0;
    endfunction

    function automatic void refresh_slot(input int s);
        for (int j = 0; j < NUM_SLOTS; j++)
            if (j != s && slot_live[j] && slot_age[j] < slot_age[s])
                slot_age[j]++;
        slot_age[s] = 0;
    endfunction

    // lowest free slot, else the least recently touched one is taken over
    function automatic int claim_slot(input logic [15:0] pkt, input int unsigned total,
                                      output bit evicted);
        int s;
        bit found;
        s = 0;
        found = 1'b0;
        evicted = 1'b0;
        for (int j = 0; j < NUM_SLOTS; j++)
            if (!found && !slot_live[j])
            begin
                s = j;
                found = 1'b1;
            end
        if (!found)
        begin
            s = 0;
            for (int j = 1; j < NUM_SLOTS; j++)
                if (slot_age[j] > slot_age[s])
                    s = j;
            free_slot(s);
            evicted = 1'b1;
        end
        for (int j = 0; j < NUM_SLOTS; j++)
            if (j != s && slot_live[j])
                slot_age[j]++;
        slot_live[s] = 1'b1;
        slot_pkt[s]  = pkt;
        slot_want[s] = total;
        slot_got[s]  = 0;
        slot_sum[s]  = 0;
        slot_age[s]  = 0;
        for (int b = 0; b < FRAG_BITS; b++)
            frag_map[s][b] = 1'b0;
        return s;
    endfunction

    function automatic tracker_result_t track_fragment(input logic [47:0] hdr);
        logic [15:0]     pkt;
        int unsigned     total;
        int unsigned     idx;
        int unsigned     len;
        int              s;
        bit              hit;
        bit              ev;
        tracker_result_t r;
        pkt   = hdr[15:0];
        total = hdr[23:16];
        idx   = hdr[31:24];
        len   = hdr[47:32];
        r = '0;
        r.status = ST_ERROR;
        if (total == 0 || idx >= total || total > FRAG_BITS)
            return r;
        if (total == 1)
        begin
            r.status = ST_COMPLETE;
            r.length = 16'(len);
            return r;
        end
        hit = 1'b0;
        s = 0;
        for (int j = 0; j < NUM_SLOTS; j++)
            if (!hit && slot_live[j] && slot_pkt[j] == pkt)
            begin
                s = j;
                hit = 1'b1;
            end
        r.used = 1'b1;
        // same packet announced with another total: slot dropped without a touch
        if (hit && slot_want[s] != total)
        begin
            r.slot = 2'(s);
            r.cleared = 1'b1;
            free_slot(s);
            return r;
        end
        ev = 1'b0;
        if (hit)
            refresh_slot(s);
        else
            s = claim_slot(pkt, total, ev);
        r.slot = 2'(s);
        r.evicted = ev;
        if (frag_map[s][idx])
            r.status = ST_DUP;
        else if (slot_sum[s] + len > byte_limit)
        begin
            r.cleared = 1'b1;
            free_slot(s);
        end
        else
        begin
            frag_map[s][idx] = 1'b1;
            slot_got[s]++;
            slot_sum[s] += len;
            if (slot_got[s] == slot_want[s])
            begin
                r.status  = ST_COMPLETE;
                r.cleared = 1'b1;
                r.length  = 16'(slot_sum[s]);
                free_slot(s);
            end
            else
                r.status = ST_PENDING;
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_val,
                                        input int unsigned act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            fail_count++;
        end
    endfunction

    initial
    begin
        fail_count = 0;
        outstanding = 0;
        byte_limit = 65535;
        for (int j = 0; j < NUM_SLOTS; j++)
            free_slot(j);
    end

    always @(posedge clk)
    begin
        tracker_result_t seen;
        tracker_result_t due;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                seen.status  = status_t'(m_tuser);
                seen.used    = m_tdata[0];
                seen.slot    = m_tdata[2:1];
                seen.evicted = m_tdata[3];
                seen.cleared = m_tdata[4];
                seen.length  = m_tdata[20:5];
                if (expected_q.size() == 0)
                begin
                    $error("result with no header waiting: status %0d, total_bytes %0d",
                           m_tuser, m_tdata[20:5]);
                    fail_count++;
                end
                else
                begin
                    due = expected_q.pop_front();
                    check_field("status", due.status, seen.status);
                    check_field("slot_used", due.used, seen.used);
                    check_field("slot_index", due.slot, seen.slot);
                    check_field("slot_evicted", due.evicted, seen.evicted);
                    check_field("slot_cleared", due.cleared, seen.cleared);
                    check_field("total_bytes", due.length, seen.length);
                end
            end
            if (cfg_valid && cfg_ready)
                byte_limit = cfg_data;
            if (s_tvalid && s_tready)
                expected_q.push_back(track_fragment(s_tdata));
            outstanding <= expected_q.size();
        end
    end

endmodule

[tb/fragment_reassembly_tracker_tb.sv]
// fragment_reassembly_tracker_tb: drives fragment headers and byte limit writes into
// the tracker and gives the verdict. Depends on frt_pkg, the tracker RTL and
// fragment_tracker_checker, which predicts and compares every result.
module fragment_reassembly_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STREAMS        = 6;
    localparam int PHASE_ITEMS    = 120;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    int          fail_count;
    int          outstanding;
    int          idle_cycles = 0;
    bit          steady = 1'b0;

    // packets being fed fragment by fragment in random order
    logic [15:0] stream_pkt   [STREAMS];
    logic [7:0]  stream_total [STREAMS];
    int          stream_left  [STREAMS];
    bit          stream_sent  [STREAMS][256];

    fragment_reassembly_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    fragment_tracker_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles == WATCHDOG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: random stall before each item, none in steady phases
    initial
    begin
        int stall;
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 3);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic send_header(input logic [15:0] pkt, input logic [7:0] total,
                               input logic [7:0] idx, input logic [15:0] len);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {len, idx, total, pkt};
        do @(posedge clk); while (!s_tready);
    endtask

    // hold the sender until every result is out, then let the pipe settle
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        wait_for_drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] draw_length();
        case ($urandom_range(0, 3))
            0:       return 16'd0;
            1:       return 16'($urandom_range(0, 15));
            2:       return 16'($urandom_range(0, 4000));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void open_stream(input int k);
        stream_pkt[k] = 16'($urandom);
        case ($urandom_range(0, 19))
            0:          stream_total[k] = 8'($urandom_range(100, 255));
            1, 2, 3, 4: stream_total[k] = 8'($urandom_range(7, 40));
            default:    stream_total[k] = 8'($urandom_range(2, 6));
        endcase
        stream_left[k] = 32'(stream_total[k]);
        for (int b = 0; b < 256; b++)
            stream_sent[k][b] = 1'b0;
    endfunction

    task automatic run_phase(input int count);
        int          k;
        int          pick;
        int          idx;
        logic [7:0]  total;
        logic [47:0] noise;
        for (int n = 0; n < count; n++)
        begin
            k = $urandom_range(0, STREAMS - 1);
            pick = $urandom_range(0, 99);
            if (stream_left[k] == 0 || pick == 99)
                open_stream(k);
            if (pick < 75)
            begin
                // fresh fragment of a tracked packet
                idx = $urandom_range(0, stream_total[k] - 1);
                while (stream_sent[k][idx])
                    idx = (idx + 1) % stream_total[k];
                stream_sent[k][idx] = 1'b1;
                stream_left[k]--;
                send_header(stream_pkt[k], stream_total[k], 8'(idx), draw_length());
            end
            else if (pick < 85)
                send_header(stream_pkt[k], stream_total[k],
                            8'($urandom_range(0, stream_total[k] - 1)), draw_length());
            else if (pick < 89)
                send_header(stream_pkt[k],
                            stream_total[k] == 8'd255 ? 8'd254 : 8'(stream_total[k] + 1),
                            8'd0, draw_length());
            else if (pick < 93)
                send_header(16'($urandom), 8'd1, 8'd0, draw_length());
            else if (pick < 96)
            begin
                total = 8'($urandom_range(0, 255));
                send_header(16'($urandom), total,
                            total == 8'd0 ? 8'($urandom) : 8'($urandom_range(total, 255)),
                            draw_length());
            end
            else
            begin
                noise = 48'({$urandom, $urandom});
                send_header(noise[15:0], noise[23:16], noise[31:24], noise[47:32]);
            end
            if ($urandom_range(0, 99) == 0)
                wait_for_drain();
        end
    endtask

    initial
    begin
        logic [15:0] phase_limit [5];
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // header checks, single fragment, duplicate, completion at full length
        send_header(16'h0000, 8'd0, 8'd0, 16'd0);
        send_header(16'h0001, 8'd3, 8'd3, 16'd10);
        send_header(16'hFFFF, 8'd1, 8'd0, 16'hFFFF);
        send_header(16'h0000, 8'd2, 8'd0, 16'd0);
        send_header(16'h0000, 8'd2, 8'd0, 16'd5);
        send_header(16'h0000, 8'd2, 8'd1, 16'hFFFF);
        send_header(16'hFFFF, 8'd255, 8'd254, 16'd1);
        send_header(16'hFFFF, 8'd255, 8'd255, 16'd1);
        // total mismatch, then byte overflow on an open slot
        send_header(16'hFFFF, 8'd254, 8'd0, 16'd1);
        send_header(16'h0007, 8'd2, 8'd0, 16'hFFFF);
        send_header(16'h0007, 8'd2, 8'd1, 16'd1);
        // fill every slot, then force replacement of the oldest
        for (int p = 10; p < 15; p++)
            send_header(16'(p), 8'd4, 8'd0, 16'd100);
        send_header(16'd11, 8'd4, 8'd1, 16'd100);
        send_header(16'd10, 8'd4, 8'd1, 16'd100);

        // zero limit: replacement and overflow in the same step
        write_limit(16'd0);
        send_header(16'd30, 8'd2, 8'd0, 16'd1);
        send_header(16'd31, 8'd3, 8'd0, 16'd0);
        send_header(16'd31, 8'd3, 8'd1, 16'd1);
        send_header(16'd32, 8'd1, 8'd0, 16'd500);

        phase_limit[0] = 16'd1;
        phase_limit[1] = 16'd5000;
        phase_limit[2] = 16'($urandom_range(2, 65534));
        phase_limit[3] = 16'd0;
        phase_limit[4] = 16'hFFFF;
        for (int k = 0; k < STREAMS; k++)
            open_stream(k);
        for (int p = 0; p < 5; p++)
        begin
            write_limit(phase_limit[p]);
            steady = (p == 1);
            run_phase(PHASE_ITEMS);
        end

        wait_for_drain();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
